FILE: rtl/lrt_pkg.sv
// Package for the logistic regression trainer: types, codes, sigmoid table.
// Used by lrt_ctrl, lrt_datapath and logistic_regression_trainer_unit.
package lrt_pkg;

  localparam int MaxDim = 64;
  localparam int IdxW = 6;
  localparam int SigEntries = 256;
  localparam int SigLog2 = $clog2(SigEntries);

  localparam logic [2:0] CmdWrite = 3'd0;
  localparam logic [2:0] CmdTrain = 3'd1;
  localparam logic [2:0] CmdPredict = 3'd2;
  localparam logic [2:0] CmdEndRound = 3'd3;
  localparam logic [2:0] CmdRead = 3'd4;

  localparam logic [1:0] CfgAlpha = 2'd0;
  localparam logic [1:0] CfgBeta = 2'd1;
  localparam logic [1:0] CfgCount = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic          buf_wr;     // store feature at pos
    logic [IdxW-1:0] pos;
    logic          w_wr;       // weight write at slot
    logic          dot_step;   // accumulate product at addr
    logic          dot_clr;
    logic          sig_calc;   // compute h from z
    logic          ae_calc;    // compute alpha*err and alpha*beta
    logic          grad_step;  // update gradient at addr
    logic          round_step; // end-round update at addr
    logic [IdxW-1:0] addr;
    logic          out_hyp;    // load output with h
    logic          out_rd;     // load output with readback
  } lrt_cmd_t;

  typedef struct packed {
    logic out_busy;
  } lrt_sts_t;

  // Long division by shift and subtract, for table elaboration only.
  function automatic logic [63:0] const_div(input logic [63:0] n, input logic [63:0] dv);
    logic [63:0] q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= dv) begin
        r = r - dv;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid table entry k, as a constant function (elaborated per index).
  function automatic logic [16:0] sig_entry(input int k);
    logic [63:0] num, d, u, u2, u3, u4, e, den, s;
    logic neg;
    num = 64'(2 * k + 1);
    neg = num < 64'(SigEntries);
    d = neg ? 64'(SigEntries) - num : num - 64'(SigEntries);
    u = (d << 25) >> SigLog2;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u4 = (u3 * u) >> 30;
    e = (64'd1 << 30) + (u2 >> 1) + const_div(u4, 64'd24) - (u + const_div(u3, 64'd6));
    for (int i = 0; i < 8; i++) e = (e * e) >> 30;
    den = (64'd1 << 30) + e;
    s = const_div((64'd1 << 46) + (den >> 1), den);
    return neg ? 17'(64'd65536 - s) : 17'(s);
  endfunction

endpackage

FILE: rtl/lrt_datapath.sv
// Datapath of the logistic regression trainer: weight, gradient and sample
// memories, dot product, sigmoid lookup, gradient and round updates. Uses lrt_pkg.
module lrt_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lrt_pkg::lrt_cmd_t    cmd_i,
  input  logic [31:0]          data_i,
  input  logic [lrt_pkg::IdxW-1:0] slot_i,
  input  logic                 label_i,
  input  logic [15:0]          alpha_i,
  input  logic [15:0]          beta_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_kind_o,
  output logic [31:0]          out_value_o,
  output logic [lrt_pkg::IdxW-1:0] out_index_o,
  output lrt_pkg::lrt_sts_t    sts_o
);

  logic signed [31:0] weights_q [lrt_pkg::MaxDim];
  logic signed [47:0] grads_q [lrt_pkg::MaxDim];
  logic signed [31:0] samples_q [lrt_pkg::MaxDim];
  logic [lrt_pkg::MaxDim-1:0] wvalid_q, gvalid_q;

  // registered reads
  logic signed [31:0] w_rd_q, x_rd_q;
  logic signed [47:0] g_rd_q;
  logic [lrt_pkg::IdxW-1:0] addr_q;
  logic dot_q, grad_q, round_q;

  // up to 64 floored products of 48 bits each
  logic signed [53:0] z_q;
  logic signed [63:0] prod_q;
  logic prod_v_q;
  logic [16:0] h_q;
  logic lab_q;
  logic signed [33:0] ae_q;
  logic [31:0] ab_q;

  logic signed [31:0] w_eff, x_eff;
  logic signed [47:0] g_eff;
  assign w_eff = wvalid_q[addr_q] ? w_rd_q : '0;
  assign g_eff = gvalid_q[addr_q] ? g_rd_q : '0;
  assign x_eff = (addr_q == '0) ? 32'sh0001_0000 : x_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_wr) samples_q[cmd_i.pos] <= data_i;
    w_rd_q <= weights_q[cmd_i.addr];
    x_rd_q <= samples_q[cmd_i.addr];
    g_rd_q <= grads_q[cmd_i.addr];
  end

  // dot product: product stage then floor-shifted accumulate
  always_ff @(posedge clk_i) begin
    prod_q <= 64'(x_eff) * 64'(w_eff);
  end

  // gradient term pipeline stage
  logic signed [65:0] te_q;
  logic signed [63:0] tb_q;
  logic signed [47:0] gsave_q;
  logic [lrt_pkg::IdxW-1:0] gaddr_q;
  logic gstage_q;
  always_ff @(posedge clk_i) begin
    te_q <= 66'(ae_q) * 66'(x_eff);
    tb_q <= 64'($signed({1'b0, ab_q})) * 64'(w_eff);
    gsave_q <= g_eff;
    gaddr_q <= addr_q;
  end

  logic signed [49:0] t_sum, g_new;
  assign t_sum = 50'((te_q + 66'sh8000_0000) >>> 32)
               - 50'((tb_q + 64'sh4000_0000) >>> 31);
  assign g_new = 50'(gsave_q) + t_sum;

  logic signed [48:0] w_full;
  assign w_full = 49'(w_eff) + 49'(g_eff);

  // sigmoid index from z
  logic [7:0] sidx;
  always_comb begin
    if (z_q < -54'sd524288) sidx = '0;
    else if (z_q > 54'sd524287) sidx = 8'hFF;
    else sidx = 8'(20'(z_q + 54'sd524288) >> 12);
  end
  logic [16:0] sig_tab [lrt_pkg::SigEntries];
  for (genvar k = 0; k < lrt_pkg::SigEntries; k++) begin : g_tab
    assign sig_tab[k] = lrt_pkg::sig_entry(k);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q <= '0;
      gvalid_q <= '0;
      dot_q <= 1'b0;
      grad_q <= 1'b0;
      round_q <= 1'b0;
      prod_v_q <= 1'b0;
      gstage_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      dot_q <= cmd_i.dot_step;
      grad_q <= cmd_i.grad_step;
      round_q <= cmd_i.round_step;
      prod_v_q <= dot_q;
      gstage_q <= grad_q;
      addr_q <= cmd_i.addr;
      if (cmd_i.w_wr) begin
        weights_q[slot_i] <= data_i;
        wvalid_q[slot_i] <= 1'b1;
      end
      // latch the label of the last feature
      if (cmd_i.dot_clr) lab_q <= label_i;
      if (cmd_i.dot_clr) z_q <= '0;
      else if (prod_v_q) z_q <= z_q + 54'(prod_q >>> 16);
      if (cmd_i.sig_calc) h_q <= sig_tab[sidx];
      if (cmd_i.ae_calc) begin
        ae_q <= 34'($signed({1'b0, alpha_i}))
              * 34'($signed({1'b0, lab_q, 16'h0}) - $signed({1'b0, h_q}));
        ab_q <= 32'(alpha_i) * 32'(beta_i);
      end
      if (gstage_q) begin
        grads_q[gaddr_q] <= (g_new > 50'sh7FFF_FFFF_FFFF) ? 48'sh7FFF_FFFF_FFFF :
                            (g_new < -50'sh8000_0000_0000) ? 48'sh8000_0000_0000 :
                            g_new[47:0];
        gvalid_q[gaddr_q] <= 1'b1;
      end
      if (round_q) begin
        weights_q[addr_q] <= (w_full > 49'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                             (w_full < -49'sh8000_0000) ? 32'sh8000_0000 : w_full[31:0];
        wvalid_q[addr_q] <= 1'b1;
        gvalid_q[addr_q] <= 1'b0;
      end
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cmd_i.out_hyp) begin
        out_valid_o <= 1'b1;
        out_kind_o <= 1'b0;
        out_value_o <= 32'(h_q);
        out_index_o <= '0;
      end else if (cmd_i.out_rd) begin
        out_valid_o <= 1'b1;
        out_kind_o <= 1'b1;
        out_value_o <= w_eff;
        out_index_o <= addr_q;
      end
    end
  end

  assign sts_o.out_busy = out_valid_o;

endmodule

FILE: rtl/lrt_ctrl.sv
// Controller of the logistic regression trainer: sequences sample walks,
// gradient updates, round updates and readback. Uses lrt_pkg.
module lrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic [lrt_pkg::IdxW-1:0] slot_i,
  input  logic [5:0]         count_i,
  input  lrt_pkg::lrt_sts_t  sts_i,
  output lrt_pkg::lrt_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDot = 3'd1;
  localparam logic [2:0] StSig = 3'd2;
  localparam logic [2:0] StAe = 3'd3;
  localparam logic [2:0] StGrad = 3'd4;
  localparam logic [2:0] StRound = 3'd5;
  localparam logic [2:0] StRead = 3'd6;
  localparam logic [2:0] StOut = 3'd7;

  logic [2:0] state_q, state_d;
  logic [6:0] cnt_q, cnt_d;
  logic [5:0] pos_q, pos_d, fc_q, fc_d;
  logic train_q, train_d;
  logic [5:0] fc;
  logic [5:0] np;

  assign fc = (count_i == '0) ? 6'd1 : count_i;
  assign np = (pos_q == 6'd63) ? 6'd63 : pos_q + 6'd1;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    fc_d = fc_q;
    train_d = train_q;
    cmd_o = '0;
    cmd_o.addr = cnt_q[5:0];
    cmd_o.pos = np;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.addr = slot_i;
        if (in_valid_i) begin
          case (cmd_i)
            lrt_pkg::CmdWrite: cmd_o.w_wr = 1'b1;
            lrt_pkg::CmdRead: begin
              // hold the slot so a stalled read keeps addressing it
              cnt_d = {1'b0, slot_i};
              state_d = StRead;
            end
            lrt_pkg::CmdEndRound: begin
              cnt_d = '0;
              state_d = StRound;
            end
            lrt_pkg::CmdTrain, lrt_pkg::CmdPredict: begin
              cmd_o.buf_wr = 1'b1;
              if (np >= fc) begin
                pos_d = '0;
                fc_d = fc;
                train_d = (cmd_i == lrt_pkg::CmdTrain);
                cnt_d = '0;
                cmd_o.dot_clr = 1'b1;
                state_d = StDot;
              end else pos_d = np;
            end
            default: ;
          endcase
        end
      end
      StRead: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_rd = 1'b1;
          state_d = StIdle;
        end
      end
      StRound: begin
        cnt_d = cnt_q + 7'd1;
        // wait at count 64 before returning to idle so the last slot update lands
        if (cnt_q == 7'(lrt_pkg::MaxDim)) state_d = StIdle;
        else cmd_o.round_step = 1'b1;
      end
      StDot: begin
        if (cnt_q <= 7'(fc_q)) cmd_o.dot_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(fc_q) + 7'd3) state_d = StSig;
      end
      StSig: begin
        cmd_o.sig_calc = 1'b1;
        cnt_d = '0;
        state_d = train_q ? StAe : StOut;
      end
      StAe: begin
        cmd_o.ae_calc = 1'b1;
        state_d = StGrad;
      end
      StGrad: begin
        cmd_o.grad_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(fc_q)) state_d = StOut;
      end
      StOut: begin
        // let the last gradient writes land before the next item
        if (!sts_i.out_busy) begin
          cmd_o.out_hyp = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q <= '0;
      pos_q <= '0;
      fc_q <= 6'd1;
      train_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      fc_q <= fc_d;
      train_q <= train_d;
    end
  end

endmodule

FILE: rtl/logistic_regression_trainer_unit.sv
// Top level of the logistic regression trainer: config registers, controller
// and datapath. Uses lrt_pkg, lrt_ctrl and lrt_datapath.
//
// Channel | Direction | Content
// s_axis  | in        | tdata: weight_index[5:0], data_value[37:6]; tuser: command; tlast: label
// m_axis  | out       | tdata: result_value[31:0], result_index[37:32]; tuser: result_kind
// cfg     | in        | cfg_index, cfg_data, register write
//
// Weight write and buffered feature: handled directly in idle. Read: waits for the output
// register, then loads the slot. Last feature: dot walk and sigmoid for a prediction, plus
// the alpha-error step and gradient walk for a training sample, then the result once the
// output register is free; end round: a walk over all slots.
// The output register holds a result while m_axis_tready is low; input stalls outside idle:
// during walks, reads, round updates and output waits. Reset is async, active low.
module logistic_regression_trainer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // weight_index[5:0], data_value[37:6], zeros
  input  logic [2:0]  s_axis_tuser,   // command[2:0]
  input  logic        s_axis_tlast,   // label
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // result_value[31:0], result_index[37:32], zeros
  output logic        m_axis_tuser,   // result_kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] alpha_q, beta_q;
  logic [5:0] count_q;
  lrt_pkg::lrt_cmd_t cmd;
  lrt_pkg::lrt_sts_t sts;
  logic [31:0] val;
  logic [5:0] idx;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 16'd66;
      beta_q <= 16'd66;
      count_q <= 6'd63;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lrt_pkg::CfgAlpha: alpha_q <= cfg_data_i;
        lrt_pkg::CfgBeta: beta_q <= cfg_data_i;
        lrt_pkg::CfgCount: count_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  lrt_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser), .slot_i(s_axis_tdata[5:0]), .count_i(count_q),
    .sts_i(sts), .cmd_o(cmd)
  );

  lrt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .data_i(s_axis_tdata[37:6]), .slot_i(s_axis_tdata[5:0]), .label_i(s_axis_tlast),
    .alpha_i(alpha_q), .beta_i(beta_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_kind_o(m_axis_tuser), .out_value_o(val), .out_index_o(idx), .sts_o(sts)
  );

  assign m_axis_tdata = {2'b00, idx, val};

endmodule
